/* rtl/age_layered_cascade_insert_top_defines.svh */
// assertion macros shared by the age-layered population store
`ifndef AGE_LAYERED_CASCADE_INSERT_TOP_DEFINES_SVH
`define AGE_LAYERED_CASCADE_INSERT_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, clocked on clk, quiet during rst
`define ALCI_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on clk, quiet during rst
`define ALCI_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ALCI_ASSERT_IMP(label, ante, cons, msg)

`define ALCI_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

/* rtl/alci_pkg.sv */
// types, constants and helpers of the age-layered population store
package alci_pkg;

  localparam int LAYERS          = 10;
  localparam int SLOTS_PER_LAYER = 10;
  localparam int POP_SIZE        = LAYERS * SLOTS_PER_LAYER;

  localparam int IDX_W   = (POP_SIZE > 1) ? $clog2(POP_SIZE) : 1;
  localparam int POS_W   = (SLOTS_PER_LAYER > 1) ? $clog2(SLOTS_PER_LAYER) : 1;
  localparam int LAYER_W = 4;
  localparam int SLOT_W  = 7;
  localparam int FIT_W   = 32;
  localparam int PAY_W   = 32;
  localparam int AGE_W   = 10;
  localparam int TS_W    = 16;
  localparam int AGE_MAX = 1023;

  // stamp = time_step / POP_SIZE by reciprocal multiply, exact for 16-bit input
  localparam int STAMP_SHIFT = TS_W + $clog2(POP_SIZE);
  localparam int STAMP_MUL   = ((2 ** STAMP_SHIFT) + POP_SIZE - 1) / POP_SIZE;
  localparam int MUL_W       = 18;
  localparam int PROD_W      = TS_W + MUL_W;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_LOAD   = 2'd1;

  localparam logic [1:0] STATUS_PLACED  = 2'd0;
  localparam logic [1:0] STATUS_BAD_LYR = 2'd1;
  localparam logic [1:0] STATUS_NO_SLOT = 2'd2;
  localparam logic [1:0] STATUS_DONE    = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STAMP,
    S_LOAD,
    S_READ,
    S_SCAN,
    S_DONE
  } alci_state_t;

  typedef struct packed {
    logic [1:0]              mode;
    logic [LAYER_W-1:0]      layer;
    logic [SLOT_W-1:0]       slot;
    logic signed [FIT_W-1:0] fit_first;
    logic signed [FIT_W-1:0] fit_second;
    logic [PAY_W-1:0]        payload;
    logic [TS_W-1:0]         time_step;
  } alci_in_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [SLOT_W-1:0]       placed_slot;
    logic signed [FIT_W-1:0] out_fit_first;
    logic signed [FIT_W-1:0] out_fit_second;
    logic [PAY_W-1:0]        out_payload;
    logic [AGE_W-1:0]        out_age;
  } alci_out_t;

  typedef struct packed {
    logic signed [FIT_W-1:0] fit_first;
    logic signed [FIT_W-1:0] fit_second;
    logic [PAY_W-1:0]        payload;
    logic [AGE_W-1:0]        age;
  } alci_entry_t;

  // per-layer age limit, layers past the table use the last entry
  function automatic logic [AGE_W-1:0] age_limit(input logic [LAYER_W-1:0] lyr);
    logic [AGE_W-1:0] lim;
    case (lyr)
      4'd0:    lim = 10'd1;
      4'd1:    lim = 10'd3;
      4'd2:    lim = 10'd5;
      4'd3:    lim = 10'd6;
      4'd4:    lim = 10'd9;
      4'd5:    lim = 10'd29;
      4'd6:    lim = 10'd30;
      4'd7:    lim = 10'd31;
      4'd8:    lim = 10'd60;
      default: lim = 10'd80;
    endcase
    return lim;
  endfunction

endpackage

/* rtl/age_layered_cascade_insert_top.sv */
// age-layered population store with cascading insert, one-read one-write slot memory
//
// The block holds a population of LAYERS x SLOTS_PER_LAYER slots (10 x 10) in
// one on-chip memory, each slot carrying two signed Q16.16 fitness values,
// a 32-bit payload word and a 10-bit age stamp. A load word writes one slot,
// a read word returns one slot, and an insert word walks the given layer
// from its first slot upward looking for the first slot whose occupant the
// newcomer beats on both objectives, or whose age is past the layer limit.
// The newcomer takes that slot with a stamp of time_step / population, and
// the evicted occupant is carried up into the next layer in the same way
// until it finds no slot or runs off the top layer. The population must be
// loaded before any insert or read touches it; unwritten slots read garbage.
// One word is worked at a time and req_ready is low while it is in flight.
// A load or read passes the stamp state and then a load or read state before
// the done state raises rsp_valid; an insert examines one slot per scan step
// along the cascade, and an insert with a start layer past the top goes
// straight from the stamp state to done. req_ready returns in the same cycle
// that rsp_valid rises, once the output register is free.
// The scan pace is set by the one memory read port: each cycle one slot
// is read while the displaced slot is written back.
// A finished response waits in the output register while the next word is
// accepted.
`include "age_layered_cascade_insert_top_defines.svh"

module age_layered_cascade_insert_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  alci_pkg::alci_in_t req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output alci_pkg::alci_out_t rsp
);

  // slot memory, one write and one registered read per cycle
  alci_pkg::alci_entry_t mem [alci_pkg::POP_SIZE];
  alci_pkg::alci_entry_t rd_entry;
  logic                           mem_we;
  logic [alci_pkg::IDX_W-1:0]     mem_waddr;
  alci_pkg::alci_entry_t          mem_wdata;
  logic [alci_pkg::IDX_W-1:0]     mem_raddr;

  // sequencer and working registers
  alci_pkg::alci_state_t state, state_next;
  logic [1:0]                        op_mode;
  logic [alci_pkg::LAYER_W-1:0]      cur_layer;
  logic [alci_pkg::SLOT_W-1:0]       slot_idx;
  logic signed [alci_pkg::FIT_W-1:0] cur_fit_first;
  logic signed [alci_pkg::FIT_W-1:0] cur_fit_second;
  logic [alci_pkg::PAY_W-1:0]        cur_payload;
  logic [alci_pkg::TS_W-1:0]         time_step;
  logic [alci_pkg::AGE_W-1:0]        stamp;
  logic [alci_pkg::IDX_W-1:0]        base;
  logic [alci_pkg::IDX_W-1:0]        idx;
  logic [alci_pkg::POS_W-1:0]        pos;
  logic                              first;
  alci_pkg::alci_out_t               res;

  // decoded conditions
  logic                              accept;
  logic                              slot_ok;
  logic                              layer_bad;
  logic                              is_load;
  logic                              is_insert;
  logic                              hit;
  logic                              last_layer;
  logic                              last_pos;
  logic                              res_load;
  logic [alci_pkg::IDX_W-1:0]        next_base;
  logic [alci_pkg::PROD_W-1:0]       stamp_prod;
  logic [alci_pkg::PROD_W-1:0]       stamp_quo;
  logic [alci_pkg::AGE_W-1:0]        stamp_sat;

  // memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_entry <= mem[mem_raddr];
  end

  // compare unit and address arithmetic
  always_comb begin
    accept     = req_valid && req_ready;
    slot_ok    = 32'(slot_idx) < alci_pkg::POP_SIZE;
    layer_bad  = 32'(cur_layer) >= alci_pkg::LAYERS;
    is_load    = op_mode == alci_pkg::MODE_LOAD;
    is_insert  = op_mode == alci_pkg::MODE_INSERT;
    // newcomer strictly better on both objectives, or the occupant is too old
    hit        = (($signed(cur_fit_first) < $signed(rd_entry.fit_first)) &&
                  ($signed(cur_fit_second) < $signed(rd_entry.fit_second))) ||
                 (rd_entry.age > alci_pkg::age_limit(cur_layer));
    last_layer = cur_layer == alci_pkg::LAYER_W'(alci_pkg::LAYERS - 1);
    last_pos   = pos == alci_pkg::POS_W'(alci_pkg::SLOTS_PER_LAYER - 1);
    res_load   = (state == alci_pkg::S_DONE) && (!rsp_valid || rsp_ready);
    next_base  = base + alci_pkg::IDX_W'(alci_pkg::SLOTS_PER_LAYER);
    // age stamp via reciprocal multiply, saturated to the stamp width
    stamp_prod = alci_pkg::PROD_W'(time_step) *
                 alci_pkg::PROD_W'(alci_pkg::STAMP_MUL);
    stamp_quo  = stamp_prod >> alci_pkg::STAMP_SHIFT;
    stamp_sat  = (stamp_quo > alci_pkg::PROD_W'(alci_pkg::AGE_MAX)) ?
                 alci_pkg::AGE_W'(alci_pkg::AGE_MAX) : alci_pkg::AGE_W'(stamp_quo);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      alci_pkg::S_IDLE: begin
        if (accept) begin
          state_next = alci_pkg::S_STAMP;
        end
      end
      alci_pkg::S_STAMP: begin
        if (is_load) begin
          state_next = alci_pkg::S_LOAD;
        end else if (!is_insert) begin
          state_next = alci_pkg::S_READ;
        end else if (layer_bad) begin
          state_next = alci_pkg::S_DONE;
        end else begin
          state_next = alci_pkg::S_SCAN;
        end
      end
      alci_pkg::S_LOAD: state_next = alci_pkg::S_DONE;
      alci_pkg::S_READ: state_next = alci_pkg::S_DONE;
      alci_pkg::S_SCAN: begin
        if (hit ? last_layer : last_pos) begin
          state_next = alci_pkg::S_DONE;
        end
      end
      alci_pkg::S_DONE: begin
        if (res_load) begin
          state_next = alci_pkg::S_IDLE;
        end
      end
      default: state_next = alci_pkg::S_IDLE;
    endcase
  end

  // outputs and memory control
  always_comb begin
    req_ready = state == alci_pkg::S_IDLE;
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = '{fit_first: cur_fit_first, fit_second: cur_fit_second,
                  payload: cur_payload, age: stamp};
    mem_raddr = idx;
    case (state)
      alci_pkg::S_STAMP: begin
        if (!is_insert) begin
          mem_raddr = slot_ok ? alci_pkg::IDX_W'(slot_idx) : '0;
        end
      end
      alci_pkg::S_LOAD: begin
        mem_we    = slot_ok;
        mem_waddr = alci_pkg::IDX_W'(slot_idx);
      end
      alci_pkg::S_SCAN: begin
        // write the carried word back on a hit, and read ahead in the same cycle
        mem_we    = hit;
        mem_raddr = hit ? next_base : idx + alci_pkg::IDX_W'(1);
      end
      default: begin
      end
    endcase
  end

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= alci_pkg::S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end

    if (res_load) begin
      rsp <= res;
    end

    case (state)
      alci_pkg::S_IDLE: begin
        if (accept) begin
          op_mode        <= req.mode;
          cur_layer      <= req.layer;
          slot_idx       <= req.slot;
          cur_fit_first  <= req.fit_first;
          cur_fit_second <= req.fit_second;
          cur_payload    <= req.payload;
          time_step      <= req.time_step;
          base           <= alci_pkg::IDX_W'(32'(req.layer) * alci_pkg::SLOTS_PER_LAYER);
          idx            <= alci_pkg::IDX_W'(32'(req.layer) * alci_pkg::SLOTS_PER_LAYER);
          pos            <= '0;
          first          <= 1'b1;
          res            <= '{status: alci_pkg::STATUS_NO_SLOT, default: '0};
        end
      end
      alci_pkg::S_STAMP: begin
        stamp <= stamp_sat;
        if (!is_insert) begin
          res.status      <= alci_pkg::STATUS_DONE;
          res.placed_slot <= slot_idx;
        end else if (layer_bad) begin
          res.status <= alci_pkg::STATUS_BAD_LYR;
        end
      end
      alci_pkg::S_READ: begin
        if (slot_ok) begin
          res.out_fit_first  <= rd_entry.fit_first;
          res.out_fit_second <= rd_entry.fit_second;
          res.out_payload    <= rd_entry.payload;
          res.out_age        <= rd_entry.age;
        end
      end
      alci_pkg::S_SCAN: begin
        if (hit) begin
          // the evicted occupant becomes the word carried upward
          cur_fit_first  <= rd_entry.fit_first;
          cur_fit_second <= rd_entry.fit_second;
          cur_payload    <= rd_entry.payload;
          cur_layer      <= cur_layer + alci_pkg::LAYER_W'(1);
          base           <= next_base;
          idx            <= next_base;
          pos            <= '0;
          first          <= 1'b0;
          if (first) begin
            res.status      <= alci_pkg::STATUS_PLACED;
            res.placed_slot <= alci_pkg::SLOT_W'(idx);
          end
        end else begin
          idx <= idx + alci_pkg::IDX_W'(1);
          pos <= pos + alci_pkg::POS_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  `ALCI_ASSERT_NXT(a_accept_to_stamp, accept, state == alci_pkg::S_STAMP,
                   "accepted word did not start")
  `ALCI_ASSERT_NXT(a_top_hit_ends, (state == alci_pkg::S_SCAN) && hit && last_layer,
                   state == alci_pkg::S_DONE, "cascade ran past top layer")
  `ALCI_ASSERT_IMP(a_write_in_range, mem_we, 32'(mem_waddr) < alci_pkg::POP_SIZE,
                   "slot write out of range")
  `ALCI_ASSERT_IMP(a_placed_in_range, res_load && (res.status == alci_pkg::STATUS_PLACED),
                   32'(res.placed_slot) < alci_pkg::POP_SIZE, "placed slot out of range")

endmodule
